FILE: sv/ddm_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and constants of the differential drive mixer
// no dependencies; imported by ddm_datapath and differential_drive_mixer_core

package ddm_pkg;

  // steering and rounding constants
  localparam int unsigned MAX_STEER_DEG  = 35;
  localparam int unsigned TAN_ROM_TOP    = 60;
  localparam int unsigned SPIN_THRESHOLD = 5;
  localparam int unsigned RATIO_FRAC     = 28;

  // field widths
  localparam int unsigned THR_W     = 9;
  localparam int unsigned ANG_W     = 7;
  localparam int unsigned DRIVE_W   = 11;
  localparam int unsigned PWM_W     = 10;
  localparam int unsigned GAIN_W    = 14;
  localparam int unsigned TAN_W     = 17;

  // internal widths
  localparam int unsigned ANG_MAG_W = ANG_W;
  localparam int unsigned SAT_W     = 6;
  localparam int unsigned MAG_W     = THR_W;
  localparam int unsigned GT_W      = GAIN_W + TAN_W;
  localparam int unsigned PROD_W    = MAG_W + GT_W;
  localparam int unsigned BASE_W    = MAG_W + RATIO_FRAC;
  localparam int unsigned VIN_W     = PROD_W + 2;
  localparam int unsigned WHEEL_W   = VIN_W - RATIO_FRAC;

  // spin speed: divide by MAX_STEER_DEG via reciprocal multiply
  localparam int unsigned SPIN_X_W     = PWM_W + SAT_W;
  localparam int unsigned SPIN_SHIFT   = 22;
  localparam int unsigned SPIN_RECIP   =
    ((1 << SPIN_SHIFT) + MAX_STEER_DEG - 1) / MAX_STEER_DEG;
  localparam int unsigned SPIN_RECIP_W = 20;
  localparam int unsigned SPIN_Q_W     = SPIN_X_W + SPIN_RECIP_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  localparam logic [PWM_W-1:0]  PWM_LIMIT_RST  = PWM_W'(255);
  localparam logic [GAIN_W-1:0] TRACK_GAIN_RST = GAIN_W'(2048);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PWM_LIMIT  = 1'b0,
    CFG_TRACK_GAIN = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PWM_W-1:0]  pwm_limit;
    logic [GAIN_W-1:0] track_gain;
  } cfg_t;

  // round(tan(d deg) * 2^16) for d = 0..60
  localparam logic [TAN_W-1:0] TAN_ROM [TAN_ROM_TOP+1] = '{
    17'd0,      17'd1144,   17'd2289,   17'd3435,   17'd4583,   17'd5734,
    17'd6888,   17'd8047,   17'd9210,   17'd10380,  17'd11556,  17'd12739,
    17'd13930,  17'd15130,  17'd16340,  17'd17560,  17'd18792,  17'd20036,
    17'd21294,  17'd22566,  17'd23853,  17'd25157,  17'd26478,  17'd27818,
    17'd29179,  17'd30560,  17'd31964,  17'd33392,  17'd34846,  17'd36327,
    17'd37837,  17'd39378,  17'd40951,  17'd42560,  17'd44205,  17'd45889,
    17'd47615,  17'd49385,  17'd51202,  17'd53070,  17'd54991,  17'd56970,
    17'd59009,  17'd61113,  17'd63287,  17'd65536,  17'd67865,  17'd70279,
    17'd72785,  17'd75391,  17'd78103,  17'd80930,  17'd83882,  17'd86969,
    17'd90203,  17'd93595,  17'd97161,  17'd100917, 17'd104880, 17'd109070,
    17'd113512
  };

endpackage

FILE: sv/ddm_datapath.sv
`timescale 1ns / 1ps
// five stage mixer datapath: decode and tan lookup, gain multiply,
// throttle multiply, rounding, wheel select and clamp; uses ddm_pkg

module ddm_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                in_valid_i,
  input  logic signed [ddm_pkg::THR_W-1:0]    throttle_i,
  input  logic signed [ddm_pkg::ANG_W-1:0]    steer_angle_i,
  input  ddm_pkg::cfg_t                       cfg_i,
  output logic                                out_valid_o,
  output logic signed [ddm_pkg::DRIVE_W-1:0]  left_drive_o,
  output logic signed [ddm_pkg::DRIVE_W-1:0]  right_drive_o,
  output logic                                spin_mode_o
);
  import ddm_pkg::*;

  // stage valid bits
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;

  // stage 1 payload
  logic [MAG_W-1:0]        s1_tmag_q;
  logic                    s1_neg_q, s1_spin_q, s1_straight_q, s1_ang_pos_q;
  logic signed [THR_W-1:0] s1_thr_q;
  logic [SAT_W-1:0]        s1_sat_q;
  logic [TAN_W-1:0]        s1_tan_q;

  // stage 2 payload
  logic [MAG_W-1:0]        s2_tmag_q;
  logic                    s2_neg_q, s2_spin_q, s2_straight_q, s2_ang_pos_q;
  logic signed [THR_W-1:0] s2_thr_q;
  logic [GT_W-1:0]         s2_gt_q;
  logic [SPIN_X_W-1:0]     s2_spin_x_q;

  // stage 3 payload
  logic [MAG_W-1:0]        s3_tmag_q;
  logic                    s3_neg_q, s3_spin_q, s3_straight_q, s3_ang_pos_q;
  logic signed [THR_W-1:0] s3_thr_q;
  logic [PROD_W-1:0]       s3_prod_q;
  logic [SPIN_Q_W-1:0]     s3_spin_q_q;

  // stage 4 payload
  logic                      s4_neg_q, s4_spin_q, s4_straight_q, s4_ang_pos_q;
  logic signed [THR_W-1:0]   s4_thr_q;
  logic signed [WHEEL_W-1:0] s4_outer_q, s4_inner_q;
  logic [PWM_W-1:0]          s4_spd_q;

  // output registers
  logic signed [DRIVE_W-1:0] left_q, right_q;
  logic                      spin_out_q;

  // stage 1: magnitudes, case flags and tan lookup
  logic [ANG_MAG_W-1:0] amag;
  logic [SAT_W-1:0]     sat, rom_idx;
  logic [MAG_W-1:0]     tmag;

  always_comb begin
    amag    = steer_angle_i[ANG_W-1] ? ANG_MAG_W'(-steer_angle_i)
                                     : ANG_MAG_W'(steer_angle_i);
    sat     = (amag > ANG_MAG_W'(MAX_STEER_DEG)) ? SAT_W'(MAX_STEER_DEG)
                                                 : amag[SAT_W-1:0];
    rom_idx = (sat > SAT_W'(TAN_ROM_TOP)) ? SAT_W'(TAN_ROM_TOP) : sat;
    tmag    = throttle_i[THR_W-1] ? MAG_W'(-throttle_i) : MAG_W'(throttle_i);
  end

  // stage 4: wheel rounding, trunc(x + 0.5) toward zero
  logic [BASE_W-1:0]        base;
  logic [PROD_W:0]          vout;
  logic signed [VIN_W-1:0]  vin, vin_neg;
  logic signed [WHEEL_W-1:0] outer, inner;

  always_comb begin
    base    = {s3_tmag_q, {RATIO_FRAC{1'b0}}} + (BASE_W'(1) << (RATIO_FRAC - 1));
    vout    = (PROD_W+1)'(base) + (PROD_W+1)'(s3_prod_q);
    vin     = $signed(VIN_W'(base)) - $signed(VIN_W'(s3_prod_q));
    vin_neg = -vin;
    outer   = $signed({1'b0, vout[PROD_W:RATIO_FRAC]});
    if (vin[VIN_W-1]) begin
      inner = -$signed({1'b0, vin_neg[VIN_W-2:RATIO_FRAC]});
    end else begin
      inner = $signed({1'b0, vin[VIN_W-2:RATIO_FRAC]});
    end
  end

  // stage 5: wheel select, throttle sign, clamp, case select
  logic signed [WHEEL_W-1:0] lim, w_l, w_r, sl, sr, cl, cr, spd;
  logic signed [DRIVE_W-1:0] left_d, right_d;

  always_comb begin
    lim = $signed(WHEEL_W'(cfg_i.pwm_limit));
    spd = $signed(WHEEL_W'(s4_spd_q));
    w_l = s4_ang_pos_q ? s4_outer_q : s4_inner_q;
    w_r = s4_ang_pos_q ? s4_inner_q : s4_outer_q;
    sl  = s4_neg_q ? -w_l : w_l;
    sr  = s4_neg_q ? -w_r : w_r;
    cl  = (sl > lim) ? lim : ((sl < -lim) ? -lim : sl);
    cr  = (sr > lim) ? lim : ((sr < -lim) ? -lim : sr);
    if (s4_spin_q) begin
      left_d  = s4_ang_pos_q ? DRIVE_W'(spd) : DRIVE_W'(-spd);
      right_d = s4_ang_pos_q ? DRIVE_W'(-spd) : DRIVE_W'(spd);
    end else if (s4_straight_q) begin
      left_d  = DRIVE_W'(s4_thr_q);
      right_d = DRIVE_W'(s4_thr_q);
    end else begin
      left_d  = DRIVE_W'(cl);
      right_d = DRIVE_W'(cr);
    end
  end

  // valid bits advance together with the payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_tmag_q     <= tmag;
      s1_neg_q      <= throttle_i[THR_W-1];
      s1_spin_q     <= (throttle_i == '0) && (amag > ANG_MAG_W'(SPIN_THRESHOLD));
      s1_straight_q <= (steer_angle_i == '0);
      s1_ang_pos_q  <= !steer_angle_i[ANG_W-1];
      s1_thr_q      <= throttle_i;
      s1_sat_q      <= sat;
      s1_tan_q      <= TAN_ROM[rom_idx];

      s2_tmag_q     <= s1_tmag_q;
      s2_neg_q      <= s1_neg_q;
      s2_spin_q     <= s1_spin_q;
      s2_straight_q <= s1_straight_q;
      s2_ang_pos_q  <= s1_ang_pos_q;
      s2_thr_q      <= s1_thr_q;
      s2_gt_q       <= GT_W'(cfg_i.track_gain) * GT_W'(s1_tan_q);
      s2_spin_x_q   <= SPIN_X_W'(s1_sat_q) * SPIN_X_W'(cfg_i.pwm_limit);

      s3_tmag_q     <= s2_tmag_q;
      s3_neg_q      <= s2_neg_q;
      s3_spin_q     <= s2_spin_q;
      s3_straight_q <= s2_straight_q;
      s3_ang_pos_q  <= s2_ang_pos_q;
      s3_thr_q      <= s2_thr_q;
      s3_prod_q     <= PROD_W'(s2_tmag_q) * PROD_W'(s2_gt_q);
      s3_spin_q_q   <= SPIN_Q_W'(s2_spin_x_q) * SPIN_Q_W'(SPIN_RECIP);

      s4_neg_q      <= s3_neg_q;
      s4_spin_q     <= s3_spin_q;
      s4_straight_q <= s3_straight_q;
      s4_ang_pos_q  <= s3_ang_pos_q;
      s4_thr_q      <= s3_thr_q;
      s4_outer_q    <= outer;
      s4_inner_q    <= inner;
      s4_spd_q      <= s3_spin_q_q[SPIN_SHIFT +: PWM_W];

      left_q        <= left_d;
      right_q       <= right_d;
      spin_out_q    <= s4_spin_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign spin_mode_o   = spin_out_q;

endmodule

FILE: sv/differential_drive_mixer_core.sv
`timescale 1ns / 1ps
// differential drive mixer top: config registers, stall control, datapath
// depends on ddm_pkg and ddm_datapath
//
// an input beat passes the stage 1 to 4 registers and the output register to output valid
// throughput: one beat per cycle when not stalled; the chained gain*tan and throttle*gain*tan
//   multiplies plus the rounding add each take a stage of their own
// the whole pipeline holds while the output register is full and not taken
// reset clears all valid bits and loads pwm_limit 255 and track_gain 2048

module differential_drive_mixer_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [ddm_pkg::THR_W-1:0]     throttle_i,
  input  logic signed [ddm_pkg::ANG_W-1:0]     steer_angle_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [ddm_pkg::DRIVE_W-1:0]   left_drive_o,
  output logic signed [ddm_pkg::DRIVE_W-1:0]   right_drive_o,
  output logic                                 spin_mode_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ddm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ddm_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import ddm_pkg::*;

  cfg_t cfg_q;
  logic en;

  // configuration writes, always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_limit  <= PWM_LIMIT_RST;
      cfg_q.track_gain <= TRACK_GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PWM_LIMIT:  cfg_q.pwm_limit  <= cfg_data_i[PWM_W-1:0];
        CFG_TRACK_GAIN: cfg_q.track_gain <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output register can take a beat
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  ddm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .in_valid_i    (in_valid_i),
    .throttle_i    (throttle_i),
    .steer_angle_i (steer_angle_i),
    .cfg_i         (cfg_q),
    .out_valid_o   (out_valid_o),
    .left_drive_o  (left_drive_o),
    .right_drive_o (right_drive_o),
    .spin_mode_o   (spin_mode_o)
  );

  // spin results turn the wheels against each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && spin_mode_o |-> right_drive_o == -left_drive_o)
    else $error("spin wheels not opposed");

  // spin speed never exceeds the configured limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && spin_mode_o |->
      (left_drive_o <= $signed({1'b0, cfg_q.pwm_limit})) &&
      (left_drive_o >= -$signed({1'b0, cfg_q.pwm_limit})))
    else $error("spin speed beyond pwm limit");

endmodule
